/* design/multi_tap_echo_macros.svh */
// Assertion helpers used by multi_tap_echo.
`ifndef MULTI_TAP_ECHO_MACROS_SVH
`define MULTI_TAP_ECHO_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mte_pkg.sv */
package mte_pkg;

    localparam int DATA_W      = 16;
    localparam int ECHO_CNT_W  = 4;
    localparam int CFG_IDX_W   = 2;

    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int MAX_ECHOES_DEF    = 8;

    localparam logic [DATA_W-1:0]     GAIN_RST   = 16'd16384;
    localparam logic [DATA_W-1:0]     DELAY_RST  = 16'd16538;
    localparam logic [ECHO_CNT_W-1:0] ECHOES_RST = 4'd2;

    // Q1.15 unity
    localparam logic [DATA_W-1:0] POW_ONE = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_DELAY  = 2'd1,
        CFG_ECHOES = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POW,
        S_TAP,
        S_FIN,
        S_OUT
    } state_t;

endpackage

/* design/multi_tap_echo.sv */
// Multi-tap feedforward echo. Each input word is one signed 16-bit sample; each
// output word is that sample plus up to echo_count earlier samples, tap i taken
// i*delay_samples back and weighted by gain_q15 to the power i (Q1.15, power
// rounded half up at every step, clamped to 65535). The sum is rounded to 16
// bits and saturated; m_clipped flags saturation. Taps that reach before the
// first stored sample or past HISTORY_DEPTH-1 are skipped. For each of the
// N = min(echo_count, MAX_ECHOES) taps a single 17x17 multiplier alternates
// between the power update and the tap product, with the history RAM read
// overlapped; then the last tap, if any, is added, and the sum is rounded into
// the output register. The input stays not ready while a word is in work, so
// a new word is taken only once the current one is done. A finished result
// sits in the output register so a new word can be taken while it waits; if
// that result is still unaccepted when the next word is done, the next word
// holds and the input stays stalled.
// Configuration (cfg_wr_en/cfg_addr/cfg_wdata) is to be written only while the
// block is idle.
module multi_tap_echo #(
    parameter int HISTORY_DEPTH = mte_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_ECHOES    = mte_pkg::MAX_ECHOES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [mte_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [mte_pkg::DATA_W-1:0]    cfg_wdata,
    // sample in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [mte_pkg::DATA_W-1:0] s_sample_in,
    // sample out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [mte_pkg::DATA_W-1:0] m_sample_out,
    output logic                          m_clipped
);
    import mte_pkg::*;
    `include "multi_tap_echo_macros.svh"

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int OFF_W  = $clog2((MAX_ECHOES + 1) * 65536);
    localparam int CMP_W  = (OFF_W > SEEN_W) ? OFF_W : SEEN_W;
    localparam int CNT_W  = $clog2(MAX_ECHOES + 1);
    // x*2^15 plus MAX_ECHOES products of at most 2^31 magnitude
    localparam int ACC_W  = 34 + $clog2(MAX_ECHOES + 1);
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int Y_W    = ACC_W - 15;

    // ---------------- configuration registers ----------------
    logic [DATA_W-1:0]     gain_reg;
    logic [DATA_W-1:0]     delay_reg;
    logic [ECHO_CNT_W-1:0] echoes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RST;
            delay_reg  <= DELAY_RST;
            echoes_reg <= ECHOES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_GAIN:   gain_reg   <= cfg_wdata;
                CFG_DELAY:  delay_reg  <= cfg_wdata;
                CFG_ECHOES: echoes_reg <= cfg_wdata[ECHO_CNT_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ---------------- state ----------------
    state_t                    state_reg, state_next;
    logic [AW-1:0]             wp_reg, wp_next;        // slot for next sample
    logic [AW-1:0]             cur_reg, cur_next;      // slot of sample in work
    logic [SEEN_W-1:0]         seen_reg, seen_next;
    logic [SEEN_W-1:0]         seen_before_reg, seen_before_next;
    logic [CNT_W-1:0]          taps_reg, taps_next;
    logic [CNT_W-1:0]          tap_cnt_reg, tap_cnt_next;
    logic [OFF_W-1:0]          off_reg, off_next;      // i*delay for current tap
    logic [DATA_W-1:0]         pow_reg, pow_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      ok_reg, ok_next;        // tap read in flight is used
    logic                      add_en_reg, add_en_next;// prod_reg holds a tap to add
    logic                      m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0]  m_sample_reg, m_sample_next;
    logic                      m_clipped_reg, m_clipped_next;

    // shared multiplier and history RAM
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [DATA_W-1:0]         rd_data;
    logic                      accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    mte_hist_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_sample_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // tap address: cur - off, wrapped into [0, DEPTH)
    logic [AW:0] diff;
    logic [AW:0] wrapped;
    logic        tap_ok;

    always_comb begin
        diff    = {1'b0, cur_reg} - {1'b0, AW'(off_reg)};
        wrapped = diff[AW] ? diff + (AW+1)'(HISTORY_DEPTH) : diff;
        rd_addr = wrapped[AW-1:0];
        tap_ok  = (CMP_W'(off_reg) <= CMP_W'(seen_before_reg)) &&
                  (CMP_W'(off_reg) <= CMP_W'(HISTORY_DEPTH - 1));
    end

    // power update from the registered product: round, shift, clamp
    logic [PROD_W-1:0]   pow_rnd;
    logic [PROD_W-16:0]  pow_wide;
    logic [DATA_W-1:0]   pow_upd;

    always_comb begin
        pow_rnd  = prod_reg + PROD_W'(16384);
        pow_wide = pow_rnd[PROD_W-1:15];
        pow_upd  = (|pow_wide[PROD_W-16:DATA_W]) ? '1 : pow_wide[DATA_W-1:0];
    end

    // output rounding and saturation
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [Y_W-1:0]   y_full;
    logic                    y_hi, y_lo;

    always_comb begin
        acc_rnd = acc_reg + ACC_W'(16384);
        y_full  = acc_rnd[ACC_W-1:15];
        y_hi    = y_full > Y_W'(32767);
        y_lo    = y_full < -Y_W'(32768);
    end

    always_comb begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        cur_next         = cur_reg;
        seen_next        = seen_reg;
        seen_before_next = seen_before_reg;
        taps_next        = taps_reg;
        tap_cnt_next     = tap_cnt_reg;
        off_next         = off_reg;
        pow_next         = pow_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        ok_next          = ok_reg;
        add_en_next      = add_en_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_sample_next    = m_sample_reg;
        m_clipped_next   = m_clipped_reg;
        mul_a            = '0;
        mul_b            = '0;
        rd_en            = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cur_next         = wp_reg;
                    wp_next          = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    seen_before_next = seen_reg;
                    if (seen_reg < SEEN_W'(HISTORY_DEPTH)) begin
                        seen_next = seen_reg + 1'b1;
                    end
                    if (int'(echoes_reg) > MAX_ECHOES) begin
                        taps_next = CNT_W'(MAX_ECHOES);
                    end else begin
                        taps_next = CNT_W'(echoes_reg);
                    end
                    tap_cnt_next = '0;
                    off_next     = OFF_W'(delay_reg);
                    pow_next     = POW_ONE;
                    acc_next     = ACC_W'(s_sample_in) <<< 15;
                    add_en_next  = 1'b0;
                    state_next   = (taps_next == '0) ? S_OUT : S_POW;
                end
            end
            S_POW: begin
                // previous tap's product lands while the multiplier does p*gain
                if (add_en_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                mul_a      = MUL_W'(pow_reg);
                mul_b      = MUL_W'(gain_reg);
                prod_next  = mul_a * mul_b;
                rd_en      = 1'b1;
                ok_next    = tap_ok;
                off_next   = off_reg + OFF_W'(delay_reg);
                state_next = S_TAP;
            end
            S_TAP: begin
                pow_next     = pow_upd;
                mul_a        = MUL_W'($signed(rd_data));
                mul_b        = MUL_W'(pow_upd);
                prod_next    = mul_a * mul_b;
                add_en_next  = ok_reg;
                tap_cnt_next = tap_cnt_reg + 1'b1;
                state_next   = (tap_cnt_next == taps_reg) ? S_FIN : S_POW;
            end
            S_FIN: begin
                if (add_en_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                add_en_next = 1'b0;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_clipped_next = y_hi || y_lo;
                    if (y_hi) begin
                        m_sample_next = 16'sh7FFF;
                    end else if (y_lo) begin
                        m_sample_next = 16'sh8000;
                    end else begin
                        m_sample_next = y_full[DATA_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            seen_reg    <= '0;
            tap_cnt_reg <= '0;
            taps_reg    <= '0;
            add_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            seen_reg    <= seen_next;
            tap_cnt_reg <= tap_cnt_next;
            taps_reg    <= taps_next;
            add_en_reg  <= add_en_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg         <= cur_next;
        seen_before_reg <= seen_before_next;
        off_reg         <= off_next;
        pow_reg         <= pow_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        ok_reg          <= ok_next;
        m_sample_reg    <= m_sample_next;
        m_clipped_reg   <= m_clipped_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_clipped    = m_clipped_reg;

    // ---------------- checks ----------------
    `MTE_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready, "input ready right after accept")
    `MTE_ASSERT_NOW(a_tap_bound, state_reg != S_IDLE, tap_cnt_reg <= taps_reg, "tap count overrun")
    `MTE_ASSERT_NOW(a_clip_rail, m_valid_reg && m_clipped_reg, (m_sample_reg == 16'sh7FFF) || (m_sample_reg == 16'sh8000), "clip flag off rail")

endmodule

/* design/mte_hist_ram.sv */
module mte_hist_ram #(
    parameter int DEPTH = mte_pkg::HISTORY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [mte_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [mte_pkg::DATA_W-1:0] rd_data
);
    import mte_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
